// ===== hw/rtl/position_report_throttle_top_macros.svh =====
// assertion macros for the position report throttle
// expects signals named clock and reset in the including module
`ifndef POSITION_REPORT_THROTTLE_TOP_MACROS_SVH
`define POSITION_REPORT_THROTTLE_TOP_MACROS_SVH

// same-cycle implication
`define PRT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PRT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/prt_pkg.sv =====
// types, constants and the arctangent table of the position report throttle
// no dependencies
package prt_pkg;

   localparam int DP_W = 34;
   localparam int CORDIC_STEPS_DEF = 24;
   localparam int DIST_W = 25;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 32;
   localparam int SQ_VW = 61;
   localparam int SQ_RW = 31;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_INTERVAL = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DISTANCE = 1'd1;

   localparam logic [1:0] WHY_HELD     = 2'd0;
   localparam logic [1:0] WHY_FIRST    = 2'd1;
   localparam logic [1:0] WHY_INTERVAL = 2'd2;
   localparam logic [1:0] WHY_DISTANCE = 2'd3;

   localparam logic [31:0] MAX_INTERVAL_RST = 32'd60000;
   localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 25'd50;

   localparam logic signed [DP_W-1:0] GAIN_INV_Q30 = 34'sd652032874;
   localparam logic signed [DP_W-1:0] PI_Q30       = 34'sd3373259426;
   localparam logic signed [DP_W-1:0] HALF_PI_Q30  = 34'sd1686629713;
   localparam logic signed [DP_W-1:0] TWO_PI_Q30   = 34'sd6746518852;
   localparam logic signed [DP_W-1:0] DEG_SCALE    = 34'sd2012227627;
   localparam logic signed [DP_W-1:0] TWO_RADIUS_M = 34'sd12742000;
   localparam logic [DIST_W-1:0] DIST_SAT = 25'd20015087;

   typedef struct packed {
      logic signed [30:0] lat_e7;
      logic signed [31:0] lon_e7;
      logic [31:0]        now_ms;
   } req_type;

   typedef struct packed {
      logic              publish;
      logic [1:0]        why;
      logic [DIST_W-1:0] distance_m;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic run;
      logic vectoring;
   } cordic_ctl_type;

   typedef struct packed {
      logic load;
      logic run;
   } sqrt_ctl_type;

   // atan(2^-i) in q30, rounded
   function automatic logic [30:0] prt_atan_q30(input logic [5:0] idx);
      logic [30:0] val;
      val = '0;
      unique case (idx)
         6'd0: val = 31'd843314857;
         6'd1: val = 31'd497837829;
         6'd2: val = 31'd263043837;
         6'd3: val = 31'd133525159;
         6'd4: val = 31'd67021687;
         6'd5: val = 31'd33543516;
         6'd6: val = 31'd16775851;
         6'd7: val = 31'd8388437;
         6'd8: val = 31'd4194283;
         6'd9: val = 31'd2097149;
         6'd31: val = 31'd1;
         default: begin
            if (idx >= 6'd10 && idx <= 6'd30) begin
               val = 31'd1 << (6'd30 - idx);
            end else begin
               val = '0;
            end
         end
      endcase
      return val;
   endfunction

endpackage

// ===== hw/rtl/position_report_throttle_top.sv =====
// position report throttle: decides per position fix whether to publish it
// depends on prt_pkg, prt_cordic, prt_isqrt and the assertion macro header
//
// req channel (valid/ready) carries one fix: lat_e7, lon_e7, now_ms.
// rsp channel (valid/ready) returns one item per fix: publish, why, distance_m.
// csr port writes max_interval_ms (index 0) and min_distance_m (index 1).
// a fix is taken only while the sequencer is idle. for the first fix and any fix
// whose elapsed time reaches the interval, the decide state goes straight to
// the done state and no distance is evaluated.
// otherwise the great-circle distance is evaluated: four sine/cosine runs on
// the shared cordic, products in states H0 to H5 on the shared multiplier,
// two square roots (each with a load state), one load and one vectoring run on
// the cordic, and scaling and decision in the DMUL, DIST and DONE states; when
// the distance forces a publish, the done state first sets the reason to
// distance and then gives the result.
// results sit in an output register, so the next fix is taken while a
// result waits; a stalled receiver holds the next result in the final state.
// reset sets the first-fix flag, clears the stored fix and time, and loads the
// register defaults (60000 ms, 50 m).
`include "position_report_throttle_top_macros.svh"
module position_report_throttle_top #(
   parameter int CORDIC_STEPS = prt_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  prt_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output prt_pkg::rsp_type                      rsp_data,
   input  logic                                  csr_we,
   input  logic [prt_pkg::CSR_IDX_W-1:0]         csr_idx,
   input  logic [prt_pkg::CSR_DATA_W-1:0]        csr_wdata
);
   import prt_pkg::*;

   localparam logic [4:0] ST_IDLE   = 5'd0;
   localparam logic [4:0] ST_DECIDE = 5'd1;
   localparam logic [4:0] ST_DIFF   = 5'd2;
   localparam logic [4:0] ST_AMUL   = 5'd3;
   localparam logic [4:0] ST_ANG    = 5'd4;
   localparam logic [4:0] ST_RED    = 5'd5;
   localparam logic [4:0] ST_ROT    = 5'd6;
   localparam logic [4:0] ST_TRIG   = 5'd7;
   localparam logic [4:0] ST_H0     = 5'd8;
   localparam logic [4:0] ST_H1     = 5'd9;
   localparam logic [4:0] ST_H2     = 5'd10;
   localparam logic [4:0] ST_H3     = 5'd11;
   localparam logic [4:0] ST_H4     = 5'd12;
   localparam logic [4:0] ST_H5     = 5'd13;
   localparam logic [4:0] ST_SQY    = 5'd14;
   localparam logic [4:0] ST_SQXL   = 5'd15;
   localparam logic [4:0] ST_SQX    = 5'd16;
   localparam logic [4:0] ST_VLOAD  = 5'd17;
   localparam logic [4:0] ST_VEC    = 5'd18;
   localparam logic [4:0] ST_DMUL   = 5'd19;
   localparam logic [4:0] ST_DIST   = 5'd20;
   localparam logic [4:0] ST_DONE   = 5'd21;
   localparam logic [4:0] ST_VINIT  = 5'd22;

   localparam logic [1:0] JOB_DLAT = 2'd0;
   localparam logic [1:0] JOB_DLON = 2'd1;
   localparam logic [1:0] JOB_LAT0 = 2'd2;
   localparam logic [1:0] JOB_LAT1 = 2'd3;

   localparam int PW = 2 * DP_W;

   logic [4:0] state_ff, state_in;
   logic [1:0] job_ff, job_in;
   req_type req_ff, req_in;
   rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic first_ff, first_in;
   logic signed [30:0] last_lat_ff, last_lat_in;
   logic signed [31:0] last_lon_ff, last_lon_in;
   logic [31:0] last_ms_ff, last_ms_in;
   logic [31:0] interval_ff, interval_in;
   logic [DIST_W-1:0] min_dist_ff, min_dist_in;
   logic [1:0] why_ff, why_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic neg_ff, neg_in;
   logic signed [DP_W-1:0] d_ff, d_in, ang_ff, ang_in;
   logic signed [DP_W-1:0] s_ff, s_in, t_ff, t_in, c1_ff, c1_in, c2_ff, c2_in;
   logic signed [DP_W-1:0] ss_ff, ss_in, tt_ff, tt_in, cc_ff, cc_in;
   logic [SQ_RW-1:0] a_ff, a_in, ry_ff, ry_in;
   logic signed [PW-1:0] prod_ff, prod_in;
   logic signed [DP_W-1:0] mul_a, mul_b;

   cordic_ctl_type cor_ctl;
   logic signed [DP_W-1:0] cor_x0, cor_y0, cor_z0, cor_x, cor_y, cor_z;
   logic cor_last;
   sqrt_ctl_type sq_ctl;
   logic [SQ_VW-1:0] sq_value;
   logic [SQ_RW-1:0] sq_root;
   logic sq_last;

   logic signed [DP_W-1:0] red1, red2, prod_q30, prod_q31, ang_mag, trig_s, trig_c;
   logic signed [DP_W:0] a_sum;
   logic [PW-1:0] dist_sum;
   logic [PW-31:0] dist_q;
   logic [31:0] elapsed;
   logic out_free;

   prt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
      .clock(clock), .reset(reset), .ctl(cor_ctl),
      .x0(cor_x0), .y0(cor_y0), .z0(cor_z0),
      .x(cor_x), .y(cor_y), .z(cor_z), .last(cor_last)
   );

   prt_isqrt u_isqrt (
      .clock(clock), .reset(reset), .ctl(sq_ctl),
      .value(sq_value), .root(sq_root), .last(sq_last)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign elapsed   = req_ff.now_ms - last_ms_ff;

   assign prod_in  = mul_a * mul_b;
   assign prod_q30 = prod_ff[DP_W+29:30];
   assign prod_q31 = prod_ff[DP_W+30:31];
   assign ang_mag  = d_ff[DP_W-1] ? -d_ff : d_ff;
   assign trig_s   = neg_ff ? -cor_y : cor_y;
   assign trig_c   = neg_ff ? -cor_x : cor_x;
   assign a_sum    = {ss_ff[DP_W-1], ss_ff} + {prod_q30[DP_W-1], prod_q30};
   assign dist_sum = prod_ff + (PW'(1) << 29);
   assign dist_q   = dist_sum[PW-1:30];

   // angle brought into [-pi, pi], then folded into [-pi/2, pi/2]
   always_comb begin
      red1 = ang_ff;
      if (ang_ff > PI_Q30) begin
         red1 = ang_ff - TWO_PI_Q30;
      end else if (ang_ff < -PI_Q30) begin
         red1 = ang_ff + TWO_PI_Q30;
      end
   end

   always_comb begin
      red2 = red1;
      neg_in = neg_ff;
      if (state_ff == ST_RED) begin
         neg_in = 1'b0;
         if (red1 > HALF_PI_Q30) begin
            red2 = red1 - PI_Q30;
            neg_in = 1'b1;
         end else if (red1 < -HALF_PI_Q30) begin
            red2 = red1 + PI_Q30;
            neg_in = 1'b1;
         end
      end
   end

   always_comb begin
      unique case (state_ff)
         ST_AMUL: begin
            mul_a = ang_mag;
            mul_b = DEG_SCALE;
         end
         ST_H0: begin
            mul_a = s_ff;
            mul_b = s_ff;
         end
         ST_H1: begin
            mul_a = t_ff;
            mul_b = t_ff;
         end
         ST_H2: begin
            mul_a = c1_ff;
            mul_b = c2_ff;
         end
         ST_H4: begin
            mul_a = cc_ff;
            mul_b = tt_ff;
         end
         ST_DMUL: begin
            mul_a = cor_z[DP_W-1] ? '0 : cor_z;
            mul_b = TWO_RADIUS_M;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      job_in = job_ff;
      req_in = req_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      first_in = first_ff;
      last_lat_in = last_lat_ff;
      last_lon_in = last_lon_ff;
      last_ms_in = last_ms_ff;
      interval_in = interval_ff;
      min_dist_in = min_dist_ff;
      why_in = why_ff;
      dist_in = dist_ff;
      d_in = d_ff;
      ang_in = ang_ff;
      s_in = s_ff;
      t_in = t_ff;
      c1_in = c1_ff;
      c2_in = c2_ff;
      ss_in = ss_ff;
      tt_in = tt_ff;
      cc_in = cc_ff;
      a_in = a_ff;
      ry_in = ry_ff;
      cor_ctl = '0;
      cor_x0 = GAIN_INV_Q30;
      cor_y0 = '0;
      cor_z0 = red2;
      sq_ctl = '0;
      sq_value = {a_ff, 30'd0};

      if (csr_we) begin
         unique case (csr_idx)
            CSR_MAX_INTERVAL: interval_in = csr_wdata;
            CSR_MIN_DISTANCE: min_dist_in = csr_wdata[DIST_W-1:0];
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            dist_in = '0;
            job_in = JOB_DLAT;
            priority if (first_ff) begin
               why_in = WHY_FIRST;
               state_in = ST_DONE;
            end else if (elapsed >= interval_ff) begin
               why_in = WHY_INTERVAL;
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            unique case (job_ff)
               JOB_DLAT: d_in = DP_W'(req_ff.lat_e7) - DP_W'(last_lat_ff);
               JOB_DLON: d_in = DP_W'(req_ff.lon_e7) - DP_W'(last_lon_ff);
               JOB_LAT0: d_in = DP_W'(last_lat_ff);
               JOB_LAT1: d_in = DP_W'(req_ff.lat_e7);
            endcase
            state_in = ST_AMUL;
         end
         ST_AMUL: begin
            state_in = ST_ANG;
         end
         ST_ANG: begin
            ang_in = (job_ff == JOB_DLAT || job_ff == JOB_DLON) ? prod_q31 : prod_q30;
            if (d_ff[DP_W-1]) begin
               ang_in = -ang_in;
            end
            state_in = ST_RED;
         end
         ST_RED: begin
            cor_ctl.load = 1'b1;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cor_ctl.run = 1'b1;
            if (cor_last) begin
               state_in = ST_TRIG;
            end
         end
         ST_TRIG: begin
            unique case (job_ff)
               JOB_DLAT: s_in = trig_s;
               JOB_DLON: t_in = trig_s;
               JOB_LAT0: c1_in = trig_c;
               JOB_LAT1: c2_in = trig_c;
            endcase
            job_in = job_ff + 2'd1;
            state_in = (job_ff == JOB_LAT1) ? ST_H0 : ST_DIFF;
         end
         ST_H0: begin
            state_in = ST_H1;
         end
         ST_H1: begin
            ss_in = prod_q30;
            state_in = ST_H2;
         end
         ST_H2: begin
            tt_in = prod_q30;
            state_in = ST_H3;
         end
         ST_H3: begin
            cc_in = prod_q30;
            state_in = ST_H4;
         end
         ST_H4: begin
            state_in = ST_H5;
         end
         ST_H5: begin
            priority if (a_sum[DP_W]) begin
               a_in = '0;
            end else if (a_sum > (DP_W+1)'(1 << 30)) begin
               a_in = SQ_RW'(1 << 30);
            end else begin
               a_in = a_sum[SQ_RW-1:0];
            end
            state_in = ST_SQY;
         end
         ST_SQY: begin
            sq_ctl.load = 1'b1;
            state_in = ST_SQXL;
         end
         ST_SQXL: begin
            sq_ctl.run = 1'b1;
            if (sq_last) begin
               state_in = ST_SQX;
            end
         end
         ST_SQX: begin
            ry_in = sq_root;
            sq_ctl.load = 1'b1;
            sq_value = {SQ_RW'(1 << 30) - a_ff, 30'd0};
            state_in = ST_VLOAD;
         end
         ST_VLOAD: begin
            sq_ctl.run = 1'b1;
            if (sq_last) begin
               state_in = ST_VINIT;
            end
         end
         ST_VINIT: begin
            cor_ctl.load = 1'b1;
            cor_ctl.vectoring = 1'b1;
            cor_x0 = DP_W'(sq_root);
            cor_y0 = DP_W'(ry_ff);
            cor_z0 = '0;
            state_in = ST_VEC;
         end
         ST_VEC: begin
            cor_ctl.run = 1'b1;
            if (cor_last) begin
               state_in = ST_DMUL;
            end
         end
         ST_DMUL: begin
            state_in = ST_DIST;
         end
         ST_DIST: begin
            if (dist_q > (PW-30)'(DIST_SAT)) begin
               dist_in = DIST_SAT;
            end else begin
               dist_in = dist_q[DIST_W-1:0];
            end
            why_in = WHY_HELD;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (why_ff == WHY_HELD && dist_ff >= min_dist_ff) begin
               why_in = WHY_DISTANCE;
            end else if (out_free) begin
               rsp_in.publish = (why_ff != WHY_HELD);
               rsp_in.why = why_ff;
               rsp_in.distance_m = dist_ff;
               rsp_valid_in = 1'b1;
               if (why_ff != WHY_HELD) begin
                  first_in = 1'b0;
                  last_lat_in = req_ff.lat_e7;
                  last_lon_in = req_ff.lon_e7;
                  last_ms_in = req_ff.now_ms;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         job_ff <= JOB_DLAT;
         rsp_valid_ff <= 1'b0;
         first_ff <= 1'b1;
         last_lat_ff <= '0;
         last_lon_ff <= '0;
         last_ms_ff <= '0;
         interval_ff <= MAX_INTERVAL_RST;
         min_dist_ff <= MIN_DISTANCE_RST;
         why_ff <= WHY_HELD;
         neg_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         job_ff <= job_in;
         rsp_valid_ff <= rsp_valid_in;
         first_ff <= first_in;
         last_lat_ff <= last_lat_in;
         last_lon_ff <= last_lon_in;
         last_ms_ff <= last_ms_in;
         interval_ff <= interval_in;
         min_dist_ff <= min_dist_in;
         why_ff <= why_in;
         neg_ff <= neg_in;
      end
      req_ff <= req_in;
      rsp_ff <= rsp_in;
      dist_ff <= dist_in;
      d_ff <= d_in;
      ang_ff <= ang_in;
      s_ff <= s_in;
      t_ff <= t_in;
      c1_ff <= c1_in;
      c2_ff <= c2_in;
      ss_ff <= ss_in;
      tt_ff <= tt_in;
      cc_ff <= cc_in;
      a_ff <= a_in;
      ry_ff <= ry_in;
      prod_ff <= prod_in;
   end

   `PRT_ASSERT_IMPL(a_publish_matches_why, rsp_valid, rsp_data.publish == (rsp_data.why != WHY_HELD), "publish flag disagrees with reason")
   `PRT_ASSERT_IMPL(a_no_distance_when_skipped, rsp_valid && (rsp_data.why == WHY_FIRST || rsp_data.why == WHY_INTERVAL), rsp_data.distance_m == '0, "distance reported without evaluation")
   `PRT_ASSERT_IMPL(a_distance_saturated, rsp_valid, rsp_data.distance_m <= DIST_SAT, "distance above saturation")
   `PRT_ASSERT_NEXT(a_first_cleared, rsp_valid_in && !rsp_valid_ff && rsp_in.publish && state_ff == ST_DONE, !first_ff, "first-fix flag not cleared after publish")

endmodule

// ===== hw/rtl/prt_cordic.sv =====
// shared cordic unit, rotation and vectoring, one iteration per cycle while run is held
// depends on prt_pkg
module prt_cordic #(
   parameter int STEPS = prt_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  prt_pkg::cordic_ctl_type             ctl,
   input  logic signed [prt_pkg::DP_W-1:0]     x0,
   input  logic signed [prt_pkg::DP_W-1:0]     y0,
   input  logic signed [prt_pkg::DP_W-1:0]     z0,
   output logic signed [prt_pkg::DP_W-1:0]     x,
   output logic signed [prt_pkg::DP_W-1:0]     y,
   output logic signed [prt_pkg::DP_W-1:0]     z,
   output logic                                last
);
   import prt_pkg::*;

   localparam int CW = $clog2(STEPS);

   logic [CW-1:0] cnt_ff, cnt_in;
   logic vec_ff, vec_in;
   logic signed [DP_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic signed [DP_W-1:0] dx, dy, ang;
   logic up;

   assign dx  = y_ff >>> cnt_ff;
   assign dy  = x_ff >>> cnt_ff;
   assign ang = signed'(DP_W'(prt_atan_q30(6'(cnt_ff))));
   assign up  = vec_ff ? y_ff[DP_W-1] : !z_ff[DP_W-1];

   always_comb begin
      cnt_in = cnt_ff;
      vec_in = vec_ff;
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      priority if (ctl.load) begin
         cnt_in = '0;
         vec_in = ctl.vectoring;
         x_in = x0;
         y_in = y0;
         z_in = z0;
      end else if (ctl.run) begin
         cnt_in = cnt_ff + 1'b1;
         if (up) begin
            x_in = x_ff - dx;
            y_in = y_ff + dy;
            z_in = z_ff - ang;
         end else begin
            x_in = x_ff + dx;
            y_in = y_ff - dy;
            z_in = z_ff + ang;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         vec_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         vec_ff <= vec_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign x = x_ff;
   assign y = y_ff;
   assign z = z_ff;
   assign last = ctl.run && (cnt_ff == CW'(STEPS - 1));

endmodule

// ===== hw/rtl/prt_isqrt.sv =====
// floor square root of a 61-bit value, one result bit per cycle while run is held
// depends on prt_pkg
module prt_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  prt_pkg::sqrt_ctl_type         ctl,
   input  logic [prt_pkg::SQ_VW-1:0]     value,
   output logic [prt_pkg::SQ_RW-1:0]     root,
   output logic                          last
);
   import prt_pkg::*;

   logic [4:0] cnt_ff, cnt_in;
   logic [SQ_VW-1:0] v_ff, v_in, r_ff, r_in, bit_val;
   logic [SQ_VW:0] trial;

   assign bit_val = SQ_VW'(1) << (6'd60 - {cnt_ff, 1'b0});
   assign trial = {1'b0, r_ff} + {1'b0, bit_val};

   always_comb begin
      cnt_in = cnt_ff;
      v_in = v_ff;
      r_in = r_ff;
      priority if (ctl.load) begin
         cnt_in = '0;
         v_in = value;
         r_in = '0;
      end else if (ctl.run) begin
         cnt_in = cnt_ff + 1'b1;
         if ({1'b0, v_ff} >= trial) begin
            v_in = v_ff - trial[SQ_VW-1:0];
            r_in = (r_ff >> 1) + bit_val;
         end else begin
            r_in = r_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      v_ff <= v_in;
      r_ff <= r_in;
   end

   assign root = r_ff[SQ_RW-1:0];
   assign last = ctl.run && (cnt_ff == 5'd30);

endmodule
